// ----- src/swht_pkg.sv -----
// ----------------------------------------------------------------------------
// swht_pkg
// shared constants, types and codes for the windowed score trigger
// ----------------------------------------------------------------------------
package swht_pkg;

    // window length and score format
    localparam int WINDOW          = 30;
    localparam int SCORE_FRAC_BITS = 15;

    // fixed field widths
    localparam int SCORE_W   = 16;
    localparam int THR_W     = 16;
    localparam int PULSE_W   = 16;
    localparam int SUM_OUT_W = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // derived widths
    localparam int CELL_W   = SCORE_FRAC_BITS + 1;
    localparam int SUM_W    = $clog2(WINDOW * (2 ** SCORE_FRAC_BITS) + 1);
    localparam int PROD_W   = THR_W + $clog2(WINDOW + 1);
    localparam int CMP_W    = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int CNT_W    = $clog2(WINDOW + 1);

    // 1.0 in the score format
    localparam logic [CELL_W-1:0] SCORE_ONE = CELL_W'(2 ** SCORE_FRAC_BITS);
    localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(WINDOW * (2 ** SCORE_FRAC_BITS));

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd3;

    // configuration reset values
    localparam logic [THR_W-1:0]   HIGH_THR_RST  = 16'd24576;
    localparam logic [THR_W-1:0]   LOW_THR_RST   = 16'd16384;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 16'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 16'd2500;

    // event codes
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } event_t;

    // decision from the hysteresis compare
    typedef struct packed {
        logic   detected;
        event_t event_code;
    } hyst_res_t;

endpackage

// ----- src/swht_cell.sv -----
// ----------------------------------------------------------------------------
// swht_cell
// one score slot of the window chain, loads from its neighbor on shift
// ----------------------------------------------------------------------------
module swht_cell (
    input  logic                       clk,
    input  logic                       shift,
    input  logic [swht_pkg::CELL_W-1:0] d,
    output logic [swht_pkg::CELL_W-1:0] q
);
    import swht_pkg::*;

    logic [CELL_W-1:0] score_reg;
    logic [CELL_W-1:0] score_next;

    always_comb
    begin
        score_next = shift ? d : score_reg;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
    end

    assign q = score_reg;

endmodule

// ----- src/swht_chain.sv -----
// ----------------------------------------------------------------------------
// swht_chain
// row of score cells; the newest score enters at the head, the score taken
// WINDOW items ago leaves at the tail
// ----------------------------------------------------------------------------
module swht_chain (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [swht_pkg::CELL_W-1:0] head,
    output logic [swht_pkg::CELL_W-1:0] tail
);
    import swht_pkg::*;

    logic [CELL_W-1:0] link [WINDOW+1];

    assign link[0] = head;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        swht_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .d     (link[i]),
            .q     (link[i+1])
        );
    end

    assign tail = link[WINDOW];

endmodule

// ----- src/swht_hyst.sv -----
// ----------------------------------------------------------------------------
// swht_hyst
// hysteresis compare of the window sum against threshold times WINDOW
// ----------------------------------------------------------------------------
module swht_hyst (
    input  logic                       full,
    input  logic [swht_pkg::SUM_W-1:0] sum,
    input  logic                       detected_in,
    input  logic [swht_pkg::THR_W-1:0] high_thr,
    input  logic [swht_pkg::THR_W-1:0] low_thr,
    output swht_pkg::hyst_res_t        res
);
    import swht_pkg::*;

    logic [CMP_W-1:0] sum_ext;
    logic [CMP_W-1:0] hi_prod;
    logic [CMP_W-1:0] lo_prod;

    // constant multiply, reduces to shifts and adds
    assign sum_ext = CMP_W'(sum);
    assign hi_prod = CMP_W'(high_thr) * CMP_W'(WINDOW);
    assign lo_prod = CMP_W'(low_thr) * CMP_W'(WINDOW);

    always_comb
    begin
        res.detected   = detected_in;
        res.event_code = EV_NONE;
        if (full)
        begin
            if (!detected_in && (sum_ext >= hi_prod))
            begin
                res.detected   = 1'b1;
                res.event_code = EV_ON;
            end
            else if (detected_in && (sum_ext < lo_prod))
            begin
                res.detected   = 1'b0;
                res.event_code = EV_OFF;
            end
        end
    end

endmodule

// ----- src/score_window_hysteresis_trigger.sv -----
// ----------------------------------------------------------------------------
// score_window_hysteresis_trigger
// moving-window mean of classifier scores with a hysteresis trigger and a
// servo pulse target at the detected or clear end point
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  in      | in_valid / in_stall        | score
//  out     | out_valid / out_stall      | window_full, window_sum, detected,
//          |                            | event_res, pulse_us
//  cfg     | cfg_we                     | cfg_index, cfg_data
//
//  one item per cycle sustained while out_stall is low; each result appears in the
//  cycle after its item is accepted, from the combinational sum / compare in front
//  of the output register
//  in_stall is raised only while a result sits in the output register and
//  out_stall holds it, so the next item is taken in the cycle the result leaves
//  reset clears the sum, fill count, hysteresis state and output valid; the
//  score cells are not cleared and are only read once all of them are filled
//
module score_window_hysteresis_trigger (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration writes
    input  logic                            cfg_we,
    input  logic [swht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swht_pkg::CFG_DAT_W-1:0]  cfg_data,

    // score items
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [swht_pkg::SCORE_W-1:0]    score,

    // result items
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            window_full,
    output logic [swht_pkg::SUM_OUT_W-1:0]  window_sum,
    output logic                            detected,
    output logic [1:0]                      event_res,
    output logic [swht_pkg::PULSE_W-1:0]    pulse_us
);
    import swht_pkg::*;

    // configuration registers
    logic [THR_W-1:0]   high_thr_reg;
    logic [THR_W-1:0]   low_thr_reg;
    logic [PULSE_W-1:0] pulse_min_reg;
    logic [PULSE_W-1:0] pulse_max_reg;

    // window state
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   seen_reg;
    logic [CNT_W-1:0]   seen_next;
    logic               detected_reg;
    logic               detected_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               full_out_reg;
    logic [SUM_OUT_W-1:0] sum_out_reg;
    logic               det_out_reg;
    event_t             event_out_reg;
    logic [PULSE_W-1:0] pulse_out_reg;

    logic               accept;
    logic               full;
    logic [CELL_W-1:0]  score_clamped;
    logic [CELL_W-1:0]  oldest;
    logic [SUM_W-1:0]   drop;
    hyst_res_t          hyst;

    // accept while the output register is empty or drains this cycle
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // comparison runs from the item after the window has filled
    assign full = (seen_reg == CNT_W'(WINDOW));

    // scores above 1.0 are stored as 1.0
    assign score_clamped = (score > SCORE_W'(SCORE_ONE)) ? SCORE_ONE : CELL_W'(score);

    // shift line of score cells, tail holds the score leaving the window
    swht_chain u_chain (
        .clk   (clk),
        .shift (accept),
        .head  (score_clamped),
        .tail  (oldest)
    );

    // running sum: add newest, drop oldest once the window is full
    assign drop     = full ? SUM_W'(oldest) : '0;
    assign sum_next = sum_reg + SUM_W'(score_clamped) - drop;

    swht_hyst u_hyst (
        .full        (full),
        .sum         (sum_next),
        .detected_in (detected_reg),
        .high_thr    (high_thr_reg),
        .low_thr     (low_thr_reg),
        .res         (hyst)
    );

    assign detected_next  = hyst.detected;
    assign seen_next      = full ? seen_reg : seen_reg + CNT_W'(1);
    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && out_stall);

    // configuration writes, the 2-bit index selects one of the four registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg  <= HIGH_THR_RST;
            low_thr_reg   <= LOW_THR_RST;
            pulse_min_reg <= PULSE_MIN_RST;
            pulse_max_reg <= PULSE_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HIGH_THR:  high_thr_reg  <= THR_W'(cfg_data);
                REG_LOW_THR:   low_thr_reg   <= THR_W'(cfg_data);
                REG_PULSE_MIN: pulse_min_reg <= PULSE_W'(cfg_data);
                REG_PULSE_MAX: pulse_max_reg <= PULSE_W'(cfg_data);
                default:       ;
            endcase
        end
    end

    // window control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            seen_reg      <= '0;
            detected_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                sum_reg      <= sum_next;
                seen_reg     <= seen_next;
                detected_reg <= detected_next;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            full_out_reg  <= full;
            sum_out_reg   <= SUM_OUT_W'(sum_next);
            det_out_reg   <= detected_next;
            event_out_reg <= hyst.event_code;
            pulse_out_reg <= detected_next ? pulse_max_reg : pulse_min_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign window_full = full_out_reg;
    assign window_sum  = sum_out_reg;
    assign detected    = det_out_reg;
    assign event_res   = event_out_reg;
    assign pulse_us    = pulse_out_reg;

    // a switch event only ever comes from a full window
    a_event_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res != EV_NONE)) |-> window_full)
        else $error("event reported before the window filled");

    // the reported state agrees with the direction of the switch
    a_event_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_res != EV_ON) || detected) &&
                      ((event_res != EV_OFF) || !detected))
        else $error("event code disagrees with detected state");

    // the running sum never exceeds a window of full-scale scores
    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("running sum out of range");

    // hysteresis state moves only with an accepted item
    a_state_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(detected_reg))
        else $error("detection state changed without an item");

endmodule
